// ===== rtl/pctdec_pkg.sv =====
// Shared types, character constants and the hex digit decoder for the percent decoder.
package pctdec_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // One input transaction.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last_char;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       field_end;
    logic       field_ok;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decodes one hex digit of either case.
  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t       h;
    logic [7:0] diff;
    h    = '0;
    diff = '0;
    case (c) inside
      [8'h30:8'h39]: begin
        diff  = c - CH_ZERO;
        h.ok  = 1'b1;
        h.val = diff[3:0];
      end
      [8'h61:8'h66]: begin
        diff  = c - CH_LOWER_A + HEX_TEN;
        h.ok  = 1'b1;
        h.val = diff[3:0];
      end
      [8'h41:8'h46]: begin
        diff  = c - CH_UPPER_A + HEX_TEN;
        h.ok  = 1'b1;
        h.val = diff[3:0];
      end
      default: begin
        h.ok  = 1'b0;
        h.val = 4'd0;
      end
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/pctdec_in_reg.sv =====
// Input register stage of the percent decoder.
module pctdec_in_reg
  import pctdec_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  load;

  // The stage frees up when its transaction moves on in the same cycle.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload capture.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/pctdec_step.sv =====
// Escape state machine and per-character decode logic.
module pctdec_step
  import pctdec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output logic    emit_o,
  output result_t res_o
);

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] high_q, high_d;
  logic       failed_q, failed_d;
  logic       seen_q, seen_d;
  hex_t       hex;
  logic       emit_char;
  logic [7:0] byte_val;
  logic [7:0] esc_val;

  assign hex     = hex_digit(item_i.ch);
  assign esc_val = {high_q, hex.val};

  // Next state and decoded byte for the transaction in the input register.
  always_comb begin
    phase_d   = phase_q;
    high_d    = high_q;
    failed_d  = failed_q;
    seen_d    = seen_q;
    emit_char = 1'b0;
    byte_val  = 8'd0;
    if (item_i.has_char) begin
      seen_d = 1'b1;
      if (!failed_q) begin
        case (phase_q)
          PH_HIGH: begin
            if (hex.ok) begin
              high_d  = hex.val;
              phase_d = PH_LOW;
            end else begin
              failed_d = 1'b1;
            end
          end
          PH_LOW: begin
            if (hex.ok) begin
              phase_d = PH_PLAIN;
              if (esc_val == 8'd0) begin
                failed_d = 1'b1;
              end else begin
                emit_char = 1'b1;
                byte_val  = esc_val;
              end
            end else begin
              failed_d = 1'b1;
            end
          end
          default: begin
            phase_d = PH_PLAIN;
            if (item_i.ch == CH_PERCENT) begin
              phase_d = PH_HIGH;
            end else if (item_i.ch == CH_COLON || item_i.ch == CH_SEMI) begin
              failed_d = 1'b1;
            end else begin
              emit_char = 1'b1;
              byte_val  = item_i.ch;
            end
          end
        endcase
      end
    end
  end

  // Result fields; the field status uses the updated state.
  always_comb begin
    res_o.ch         = byte_val;
    res_o.char_valid = emit_char;
    res_o.field_end  = item_i.last_char;
    res_o.field_ok   = item_i.last_char && seen_d && !failed_d && (phase_d == PH_PLAIN);
  end

  assign emit_o = emit_char || item_i.last_char;

  // State update; a field end returns everything to the reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_PLAIN;
      high_q   <= 4'd0;
      failed_q <= 1'b0;
      seen_q   <= 1'b0;
    end else if (fire_i) begin
      if (item_i.last_char) begin
        phase_q  <= PH_PLAIN;
        high_q   <= 4'd0;
        failed_q <= 1'b0;
        seen_q   <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        high_q   <= high_d;
        failed_q <= failed_d;
        seen_q   <= seen_d;
      end
    end
  end

endmodule

// ===== rtl/pctdec_out_reg.sv =====
// Result register stage of the percent decoder.
module pctdec_out_reg
  import pctdec_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    ready_o,
  output logic    out_valid_o,
  output result_t res_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  // The register can take a new result when empty or when its result leaves.
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload capture.
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/percent_escape_decoder.sv =====
// Top level of the percent-escape decoder.
// The decoder takes one raw character per transaction and returns at most one
// result per transaction: a decoded byte, a field end with its status, or both.
// It sustains one transaction per clock cycle while the output is not stalled;
// an item passes through an input register and then a result register, which
// presents its result, and a stalled output holds both registers until it clears.
// Items with neither a character nor a field end, and characters that only open
// or continue an escape, give no result.
// When field_ok_o is low at field end, the bytes delivered for that field must be
// discarded.
module percent_escape_decoder
  import pctdec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       has_char_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       field_end_o,
  output logic       field_ok_o
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    out_ready;
  logic    fire;
  logic    emit;
  result_t step_res;
  result_t out_res;

  assign in_item.ch        = in_char_i;
  assign in_item.has_char  = has_char_i;
  assign in_item.last_char = last_char_i;

  // The input register advances whenever the result register can accept.
  assign fire = s1_valid && out_ready;

  pctdec_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .item_i    (in_item),
    .take_i    (fire),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  pctdec_step u_step (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(s1_item),
    .emit_o(emit),
    .res_o (step_res)
  );

  pctdec_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && emit),
    .res_i      (step_res),
    .out_stall_i(out_stall_i),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .res_o      (out_res)
  );

  assign out_char_o   = out_res.ch;
  assign char_valid_o = out_res.char_valid;
  assign field_end_o  = out_res.field_end;
  assign field_ok_o   = out_res.field_ok;

endmodule

// ===== verif/percent_escape_decoder_tb.sv =====
// Self-checking testbench for the percent-escape decoder: directed fields, then random fields.
module percent_escape_decoder_tb;
  import pctdec_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 7;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_FROM  = 1700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 40;

  // Position inside a percent escape.
  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } esc_phase_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_char_i;
  logic       has_char_i;
  logic       last_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_char_o;
  logic       char_valid_o;
  logic       field_end_o;
  logic       field_ok_o;

  // Decoder state tracked by the testbench.
  esc_phase_e esc_phase;
  logic [3:0] hi_nib;
  logic       field_failed;
  logic       field_seen;

  result_t    decoded_q[$];
  int         mismatch_count;
  int         items_sent;
  int         cycle_count;
  bit         idle_on;
  bit         stall_on;
  int         stall_left;

  percent_escape_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_char_i   (in_char_i),
    .has_char_i  (has_char_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .char_valid_o(char_valid_o),
    .field_end_o (field_end_o),
    .field_ok_o  (field_ok_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Prints one mismatch line, up to a limit, and counts every mismatch.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Returns 1 for a hex digit of either case and gives its value.
  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the tracked state by one accepted transaction and queues its result.
  function automatic void decode_step(input logic [7:0] ch, input logic has,
                                      input logic last);
    result_t    res;
    logic [3:0] nib;
    logic       digit_ok;
    logic       emit;
    logic [7:0] byte_v;
    emit   = 1'b0;
    byte_v = 8'd0;
    digit_ok = hex_nibble(ch, nib);
    if (has) begin
      field_seen = 1'b1;
      if (!field_failed) begin
        case (esc_phase)
          PH_HIGH: begin
            if (digit_ok) begin
              hi_nib    = nib;
              esc_phase = PH_LOW;
            end else begin
              field_failed = 1'b1;
            end
          end
          PH_LOW: begin
            if (digit_ok) begin
              esc_phase = PH_PLAIN;
              if ({hi_nib, nib} == 8'd0) begin
                field_failed = 1'b1;
              end else begin
                emit   = 1'b1;
                byte_v = {hi_nib, nib};
              end
            end else begin
              field_failed = 1'b1;
            end
          end
          default: begin
            esc_phase = PH_PLAIN;
            if (ch == CH_PERCENT) begin
              esc_phase = PH_HIGH;
            end else if (ch == CH_COLON || ch == CH_SEMI) begin
              field_failed = 1'b1;
            end else begin
              emit   = 1'b1;
              byte_v = ch;
            end
          end
        endcase
      end
    end
    if (emit || last) begin
      res.ch         = byte_v;
      res.char_valid = emit;
      res.field_end  = last;
      res.field_ok   = last && field_seen && !field_failed && esc_phase == PH_PLAIN;
      decoded_q.push_back(res);
    end
    if (last) begin
      esc_phase    = PH_PLAIN;
      hi_nib       = 4'd0;
      field_failed = 1'b0;
      field_seen   = 1'b0;
    end
  endfunction

  // Sends one transaction, with an optional idle burst first, and predicts it.
  task automatic send_item(input logic [7:0] ch, input logic has, input logic last);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i  = 1'b0;
      in_char_i   = 8'($urandom);
      has_char_i  = 1'($urandom);
      last_char_i = 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    in_char_i   = has ? ch : 8'($urandom);
    has_char_i  = has;
    last_char_i = last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    decode_step(in_char_i, has, last);
    if (has || last) items_sent++;
  endtask

  // Sends a string as one field, closing it on the last character.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b1, i == s.len() - 1);
    end
  endtask

  // Holds the sender until every expected result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Any character that passes through unchanged.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_PERCENT || c == CH_COLON || c == CH_SEMI);
    return c;
  endfunction

  // A hex digit for the given value, in a random case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 4'd10);
  endfunction

  // Any character that is not a hex digit.
  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [3:0] v;
    do c = 8'($urandom); while (hex_nibble(c, v));
    return c;
  endfunction

  // Raw characters at both ends of the byte range pass through.
  task automatic test_plain_chars();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
  endtask

  // Escapes in both cases, including one completed on the closing transaction.
  task automatic test_escapes();
    send_text("%41%fF");
  endtask

  // An escape of value zero fails the field and silences the rest of it.
  task automatic test_zero_escape();
    send_text("%00x");
  endtask

  // A non-hex character after the percent sign fails the field.
  task automatic test_bad_digit();
    send_text("%g");
  endtask

  // Raw colon and semicolon fail the field.
  task automatic test_separators();
    send_text(":");
    send_text(";a");
  endtask

  // A transaction with no character and no end is ignored; a bare end alone is empty.
  task automatic test_empty_and_ignored();
    send_item(8'($urandom), 1'b0, 1'b0);
    send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Fields that end inside an escape, with and without a bare end.
  task automatic test_open_escape();
    send_text("%");
    send_item(CH_PERCENT, 1'b1, 1'b0);
    send_item("9", 1'b1, 1'b0);
    send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // One random field: mostly well-formed tokens, with some broken ones mixed in.
  task automatic random_field();
    int         n_tok;
    int         kind;
    bit         bare_end;
    bit         closing;
    bit         with_digit;
    logic [7:0] esc_val;
    if ($urandom_range(0, 30) == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      return;
    end
    n_tok    = $urandom_range(1, 6);
    bare_end = ($urandom_range(0, 3) == 0);
    for (int t = 0; t < n_tok; t++) begin
      closing = (t == n_tok - 1) && !bare_end;
      kind    = $urandom_range(0, 19);
      if (kind < 9) begin
        send_item(plain_char(), 1'b1, closing);
      end else if (kind < 16) begin
        esc_val = 8'($urandom);
        send_item(CH_PERCENT, 1'b1, 1'b0);
        send_item(hex_char(esc_val[7:4]), 1'b1, 1'b0);
        send_item(hex_char(esc_val[3:0]), 1'b1, closing);
      end else if (kind == 16) begin
        send_item($urandom_range(0, 1) ? CH_COLON : CH_SEMI, 1'b1, closing);
      end else if (kind == 17) begin
        with_digit = 1'($urandom);
        send_item(CH_PERCENT, 1'b1, closing && !with_digit);
        if (with_digit) send_item(hex_char(4'($urandom)), 1'b1, closing);
      end else if (kind == 18) begin
        send_item(CH_PERCENT, 1'b1, 1'b0);
        if ($urandom_range(0, 1)) send_item(hex_char(4'($urandom)), 1'b1, 1'b0);
        send_item(non_hex_char(), 1'b1, closing);
      end else begin
        send_item(8'($urandom), 1'b0, 1'b0);
        send_item(plain_char(), 1'b1, closing);
      end
    end
    if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Random fields until the item budget is spent; the last stretch has no idles or stalls.
  task automatic test_random_fields();
    int start_count;
    bit paused;
    start_count = items_sent;
    paused      = 1'b0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if (!paused && items_sent - start_count >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if (items_sent - start_count >= QUIET_FROM) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      random_field();
    end
  endtask

  // Output stall in random bursts, driven at the falling edge.
  initial begin
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
      end else if (stall_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      out_stall_i = (stall_left > 0);
    end
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing expected", int'(out_char_o), 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_char_o !== want.ch) begin
          report_mismatch("out_char", int'(out_char_o), int'(want.ch));
        end
        if (char_valid_o !== want.char_valid) begin
          report_mismatch("char_valid", int'(char_valid_o), int'(want.char_valid));
        end
        if (field_end_o !== want.field_end) begin
          report_mismatch("field_end", int'(field_end_o), int'(want.field_end));
        end
        if (field_ok_o !== want.field_ok) begin
          report_mismatch("field_ok", int'(field_ok_o), int'(want.field_ok));
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_char_i      = 8'd0;
    has_char_i     = 1'b0;
    last_char_i    = 1'b0;
    esc_phase      = PH_PLAIN;
    hi_nib         = 4'd0;
    field_failed   = 1'b0;
    field_seen     = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    idle_on        = 1'b1;
    stall_on       = 1'b1;
    repeat (RESET_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_plain_chars();
    test_escapes();
    test_zero_escape();
    drain_results();
    test_bad_digit();
    test_separators();
    test_empty_and_ignored();
    test_open_escape();
    drain_results();
    test_random_fields();

    // Let the pipeline empty out before judging the run.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
